// File: rtl/core/assert_macros.svh
// Assertion helpers for the scheduler RTL.
// Both macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scheduler forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 8;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int COUNT_W     = 5;
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ID_W-1:0] BOOT_ID       = ID_W'(0);
    localparam logic [ID_W-1:0] IDLE_ID_RESET = ID_W'(1);

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD  = 2'd0,
        REQ_KILL = 2'd1,
        REQ_TICK = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request fields
        logic exec;     // apply captured request to the queue
        logic cfg_wr;   // write idle task id
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/core/rrts_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module rrts_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    output logic                   o_strobe,
    output rrts_pkg::t_dp_cmd      o_cmd
);

    rrts_pkg::t_state r_state;
    rrts_pkg::t_state n_state;
    logic             r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrts_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_cmd.exec;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rrts_pkg::S_IDLE: begin
                if (start) n_state = rrts_pkg::S_EXEC;
            end
            rrts_pkg::S_EXEC: begin
                n_state = rrts_pkg::S_IDLE;
            end
            default: begin
                n_state = rrts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy         = 1'b0;
        o_cfg_ready  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.cfg_wr = 1'b0;
        case (r_state)
            rrts_pkg::S_IDLE: begin
                o_cfg_ready  = 1'b1;
                o_cmd.load   = start;
                o_cmd.cfg_wr = i_cfg_valid;
            end
            rrts_pkg::S_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    assign o_strobe = r_strobe;

    `ASSERT_CLK(a_exec_single, i_clk, i_rst_n, r_state == rrts_pkg::S_EXEC |=> r_state == rrts_pkg::S_IDLE)
    `ASSERT_CLK(a_load_to_strobe, i_clk, i_rst_n, o_cmd.load |=> o_cmd.exec ##1 r_strobe)
    `ASSERT_NEVER(a_cfg_while_busy, i_clk, i_rst_n, o_cmd.cfg_wr && busy)

endmodule

`default_nettype wire

// File: rtl/core/rrts_dp.sv
`default_nettype none
`include "assert_macros.svh"

module rrts_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rrts_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [rrts_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [rrts_pkg::ID_W-1:0]         i_task_id,
    input  wire logic [rrts_pkg::ID_W-1:0]         i_cfg_data,
    output logic      [rrts_pkg::ID_W-1:0]         o_running_task,
    output logic      [rrts_pkg::STAT_W-1:0]       o_status,
    output logic      [rrts_pkg::COUNT_W-1:0]      o_ready_count
);

    localparam int DEPTH = rrts_pkg::QUEUE_DEPTH;
    localparam int IW    = rrts_pkg::ID_W;
    localparam int LW    = rrts_pkg::LEN_W;

    // queue row: cell 0 is the head
    logic [IW-1:0]              r_cells [DEPTH];
    logic [IW-1:0]              n_cells [DEPTH];
    logic [IW-1:0]              shifted [DEPTH];
    logic [LW-1:0]              r_len;
    logic [LW-1:0]              n_len;
    logic [IW-1:0]              r_running;
    logic [IW-1:0]              n_running;
    logic [IW-1:0]              r_idle;
    logic [rrts_pkg::REQ_W-1:0] r_req;
    logic [IW-1:0]              r_id;
    rrts_pkg::t_status          r_status;
    rrts_pkg::t_status          n_status;

    logic [DEPTH-1:0]           match;
    logic [DEPTH-1:0]           close_gap;
    logic                       found;
    logic                       full;
    logic                       empty;
    logic                       requeue;

    // per-cell compare, then prefix OR so every cell at or after the
    // first match pulls from its upper neighbour
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i]     = (LW'(i) < r_len) && (r_cells[i] == r_id);
            seen         = seen | match[i];
            close_gap[i] = seen;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            shifted[i] = r_cells[i + 1];
        end
        shifted[DEPTH-1] = r_running;
    end

    assign found   = |match;
    assign full    = (r_len == LW'(DEPTH));
    assign empty   = (r_len == '0);
    assign requeue = (r_running != rrts_pkg::BOOT_ID) && (r_running != r_idle);

    always_comb begin
        n_cells   = r_cells;
        n_len     = r_len;
        n_running = r_running;
        n_status  = rrts_pkg::ST_OK;
        case (r_req)
            rrts_pkg::REQ_ADD: begin
                if (full) begin
                    n_status = rrts_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (LW'(i) == r_len) n_cells[i] = r_id;
                    end
                    n_len = r_len + LW'(1);
                end
            end
            rrts_pkg::REQ_KILL: begin
                if (found) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (close_gap[i]) n_cells[i] = shifted[i];
                    end
                    n_len = r_len - LW'(1);
                end else begin
                    n_status = rrts_pkg::ST_NOT_FOUND;
                end
            end
            rrts_pkg::REQ_TICK: begin
                if (requeue) begin
                    // append the running task, then pop the head; length holds
                    n_running = empty ? r_running : r_cells[0];
                    for (int i = 0; i < DEPTH; i++) begin
                        n_cells[i] = (LW'(i + 1) == r_len) ? r_running : shifted[i];
                    end
                end else if (empty) begin
                    n_running = r_idle;
                end else begin
                    n_running = r_cells[0];
                    n_cells   = shifted;
                    n_len     = r_len - LW'(1);
                end
            end
            default: begin
                n_status = rrts_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_running <= rrts_pkg::BOOT_ID;
            r_idle    <= rrts_pkg::IDLE_ID_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_len     <= n_len;
                r_running <= n_running;
            end
            if (i_cmd.cfg_wr) r_idle <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_id  <= i_task_id;
        end
        if (i_cmd.exec) begin
            r_cells  <= n_cells;
            r_status <= n_status;
        end
    end

    assign o_running_task = r_running;
    assign o_status       = r_status;
    assign o_ready_count  = rrts_pkg::COUNT_W'(r_len);

    `ASSERT_NEVER(a_len_bound, i_clk, i_rst_n, r_len > LW'(DEPTH))
    `ASSERT_CLK(a_add_grows, i_clk, i_rst_n,
        (i_cmd.exec && r_req == rrts_pkg::REQ_ADD && !full)
            |=> r_len == ($past(r_len) + LW'(1)))
    `ASSERT_CLK(a_kill_miss_holds, i_clk, i_rst_n,
        (i_cmd.exec && r_req == rrts_pkg::REQ_KILL && !found)
            |=> $stable(r_len) && $stable(r_running))

endmodule

`default_nettype wire

// File: rtl/core/round_robin_task_scheduler.sv
`default_nettype none

// Round-robin task scheduler. A request is taken when start is high and busy
// is low; the queue row updates in the following cycle (busy high for that one
// cycle) and the result is shown with o_strobe high for exactly one cycle after
// that. No new request is taken while busy is high, but one can be taken in the
// strobe cycle itself. A capture register sits in front of the shift-register
// queue, which matches and closes gaps in all cells at once. The receiver
// cannot stall: each result must be taken in its strobe cycle. The idle task
// id is written through the cfg channel, which is ready only while busy is low.
module round_robin_task_scheduler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [rrts_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [rrts_pkg::ID_W-1:0]       i_task_id,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rrts_pkg::ID_W-1:0]       i_cfg_data,
    output logic                                 o_strobe,
    output logic      [rrts_pkg::ID_W-1:0]       o_running_task,
    output logic      [rrts_pkg::STAT_W-1:0]     o_status,
    output logic      [rrts_pkg::COUNT_W-1:0]    o_ready_count
);

    rrts_pkg::t_dp_cmd cmd;

    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_strobe    (o_strobe),
        .o_cmd       (cmd)
    );

    rrts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_task_id      (i_task_id),
        .i_cfg_data     (i_cfg_data),
        .o_running_task (o_running_task),
        .o_status       (o_status),
        .o_ready_count  (o_ready_count)
    );

endmodule

`default_nettype wire

// File: tb/sv/round_robin_task_scheduler_tb.sv
`default_nettype none

module round_robin_task_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrts_pkg::*;

    // request code with no operation behind it
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 185;
    localparam int QUIET_LIMIT = 1000;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0]  id;
    } sched_req_t;

    typedef struct {
        logic [ID_W-1:0]    running;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } sched_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [REQ_W-1:0]     i_req_type = '0;
    logic [ID_W-1:0]      i_task_id = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [ID_W-1:0]      i_cfg_data = '0;
    logic                 o_strobe;
    logic [ID_W-1:0]      o_running_task;
    logic [STAT_W-1:0]    o_status;
    logic [COUNT_W-1:0]   o_ready_count;

    round_robin_task_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_task_id      (i_task_id),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_running_task (o_running_task),
        .o_status       (o_status),
        .o_ready_count  (o_ready_count)
    );

    // scheduler state as predicted
    logic [ID_W-1:0] ready_model[$];
    logic [ID_W-1:0] running_model = BOOT_ID;
    logic [ID_W-1:0] idle_model = IDLE_ID_RESET;

    sched_req_t    pending_reqs[$];
    sched_result_t expected_results[$];

    int issued_count = 0;
    int result_count = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int gap_pct = 19;

    logic [ID_W-1:0] idle_settings [NUM_PHASES] = '{8'hFF, 8'h00, 8'h03, 8'h80, 8'h01};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void schedule_step(input logic [REQ_W-1:0] kind,
                                          input logic [ID_W-1:0] id);
        sched_result_t res;
        int hit;
        logic requeue;
        res.status = ST_OK;
        case (kind)
            REQ_ADD: begin
                if (ready_model.size() < QUEUE_DEPTH) begin
                    ready_model.push_back(id);
                end else begin
                    res.status = ST_FULL;
                end
            end
            REQ_KILL: begin
                hit = -1;
                for (int i = 0; i < ready_model.size(); i++) begin
                    if (hit < 0 && ready_model[i] == id) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    ready_model.delete(hit);
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            REQ_TICK: begin
                // append then pop: on a full queue the head leaves first, same outcome
                requeue = running_model != BOOT_ID && running_model != idle_model;
                if (requeue) begin
                    ready_model.push_back(running_model);
                end
                if (ready_model.size() == 0) begin
                    running_model = idle_model;
                end else begin
                    running_model = ready_model.pop_front();
                end
            end
            default: begin
            end
        endcase
        res.running = running_model;
        res.count = COUNT_W'(ready_model.size());
        expected_results.push_back(res);
    endfunction

    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id);
        sched_req_t r;
        r.kind = kind;
        r.id = id;
        pending_reqs.push_back(r);
        issued_count++;
    endtask

    task automatic queue_random_req(input int add_pct);
        int roll;
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) kind = REQ_ADD;
        else if (roll < add_pct + (95 - add_pct) / 2) kind = REQ_KILL;
        else if (roll < 95) kind = REQ_TICK;
        else kind = REQ_UNUSED;
        // small id pool so kills hit and duplicates build up
        roll = $urandom_range(0, 99);
        if (roll < 70) id = ID_W'($urandom_range(0, 7));
        else if (roll < 85) id = idle_model;
        else id = ID_W'($urandom);
        queue_req(kind, id);
    endtask

    task automatic wait_drained();
        while (result_count < issued_count) @(posedge i_clk);
    endtask

    task automatic write_idle_id(input logic [ID_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        idle_model = value;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= ID_W'($urandom);
    endtask

    always @(posedge i_clk) begin : request_driver
        sched_req_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                schedule_step(i_req_type, i_task_id);
            end
            // a request not yet taken stays on the ports
            if (!(start && busy)) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    nxt = pending_reqs.pop_front();
                    start <= 1'b1;
                    i_req_type <= nxt.kind;
                    i_task_id <= nxt.id;
                end else begin
                    start <= 1'b0;
                    i_req_type <= REQ_W'($urandom);
                    i_task_id <= ID_W'($urandom);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        sched_result_t want;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (o_strobe) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: running_task %0d", o_running_task);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_running_task !== want.running) begin
                        $error("running_task: expected %0d, got %0d",
                               want.running, o_running_task);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_ready_count !== want.count) begin
                        $error("ready_count: expected %0d, got %0d",
                               want.count, o_ready_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, idle id at its reset value
        queue_req(REQ_TICK, 8'h00);     // boot task not requeued, empty queue -> idle
        queue_req(REQ_KILL, 8'h00);     // kill on empty queue
        queue_req(REQ_ADD, 8'h00);
        queue_req(REQ_ADD, 8'hFF);
        queue_req(REQ_ADD, IDLE_ID_RESET);
        queue_req(REQ_ADD, 8'h05);
        queue_req(REQ_ADD, 8'h05);      // duplicate
        queue_req(REQ_KILL, 8'h05);     // first match only
        queue_req(REQ_TICK, 8'h00);     // idle not requeued
        queue_req(REQ_TICK, 8'hAA);     // boot not requeued, 255 starts
        queue_req(REQ_KILL, 8'hFF);     // running task is not in the queue
        queue_req(REQ_UNUSED, 8'hFF);
        for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
            queue_req(REQ_ADD, ID_W'(i * 17 + 2));
        end
        queue_req(REQ_ADD, 8'h7E);      // refused, full
        queue_req(REQ_TICK, 8'h55);     // requeue into a full queue
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_idle_id(idle_settings[p]);
            gap_pct = (p == 2) ? 0 : 19;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_req((p % 2 == 0) ? 55 : 35);
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_ctrl.sv
rtl/core/rrts_dp.sv
rtl/core/round_robin_task_scheduler.sv
tb/sv/round_robin_task_scheduler_tb.sv
